FILE: sv/prsp_pkg.sv
// Shared constants, widths and code types for the packet rate shaper/policer.
// No dependencies; compiled first.
package prsp_pkg;

   localparam int FRAC_BITS     = 16;
   localparam int WIRE_OVERHEAD = 24;

   localparam int TIME_W    = 64;
   localparam int CFG_W     = 32;
   localparam int BYTES_W   = 16;
   localparam int CHARGE_W  = BYTES_W + 1;
   localparam int TOKEN_W   = CFG_W + FRAC_BITS;
   localparam int ADD_W     = CHARGE_W + CFG_W;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [1:0] {
      MODE_DELAY,
      MODE_SHAPER,
      MODE_POLICER
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SHAPING_MODE,
      CSR_ADDED_DELAY,
      CSR_BYTES_PER_NS,
      CSR_NS_PER_BYTE,
      CSR_CAPACITY
   } csr_index_type;

endpackage

FILE: sv/prsp_if.sv
// Valid/ready channel interfaces: packet request, verdict response, register write.
// Depends on prsp_pkg.
interface prsp_req_if;
   logic                           valid;
   logic                           ready;
   logic [prsp_pkg::TIME_W-1:0]    arrival_ns;
   logic [prsp_pkg::BYTES_W-1:0]   packet_bytes;
   modport source (output valid, arrival_ns, packet_bytes, input ready);
   modport sink   (input valid, arrival_ns, packet_bytes, output ready);
endinterface

interface prsp_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           accepted;
   logic [prsp_pkg::TIME_W-1:0]    send_ns;
   modport source (output valid, accepted, send_ns, input ready);
   modport sink   (input valid, accepted, send_ns, output ready);
endinterface

interface prsp_csr_if;
   logic                            valid;
   logic                            ready;
   logic [prsp_pkg::CSR_IDX_W-1:0]  index;
   logic [prsp_pkg::CFG_W-1:0]      data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/packet_rate_shaper_policer.sv
// Packet rate shaper / policer top level: delay, leaky-bucket shaper, token-bucket policer.
// Depends on prsp_pkg and the channel interfaces in prsp_if.sv.
// An accepted word is held in the input stage, then its verdict in the result stage.
// Throughput: one word per cycle unless rsp stalls; state updates in the single compute stage.
// Reset: synchronous; clears config registers, bucket state and both stage valids.
module packet_rate_shaper_policer (
   input  logic            clock,
   input  logic            reset,
   prsp_req_if.sink        req_chan,
   prsp_rsp_if.source      rsp_chan,
   prsp_csr_if.sink        csr_chan
);
   import prsp_pkg::*;

   localparam int EHI_W  = TOKEN_W - CFG_W;
   localparam int PROD_W = TOKEN_W + CFG_W;

   // configuration
   logic [1:0]             mode_ff;
   logic [CFG_W-1:0]       delay_ff, rate_ff, npb_ff, cap_ff;

   // input stage
   logic                   s1_valid_ff;
   logic [TIME_W-1:0]      arrival_ff;
   logic [BYTES_W-1:0]     bytes_ff;

   // bucket state
   logic [TIME_W-1:0]      last_ff, last_in;
   logic [TOKEN_W-1:0]     token_ff, token_in;
   logic [TIME_W-1:0]      nf_ns_ff, nf_ns_in;
   logic [FRAC_BITS-1:0]   nf_frac_ff, nf_frac_in;

   // result stage
   logic                   rsp_valid_ff;
   logic                   accepted_ff, accepted_in;
   logic [TIME_W-1:0]      send_ff, send_in;

   logic                   advance;

   // shared
   logic [CHARGE_W-1:0]    charge;
   logic [TIME_W-1:0]      delayed;

   // shaper
   logic                   later;
   logic [TIME_W-1:0]      real_int, back_int, back_q;
   logic [FRAC_BITS-1:0]   real_frac;
   logic [2*CFG_W-1:0]     bound;
   logic                   shp_drop;
   logic [ADD_W-1:0]       add_ns;
   logic [FRAC_BITS:0]     frac_sum;
   logic [TIME_W-1:0]      nf_next;

   // policer
   logic [TIME_W-1:0]      elapsed;
   logic [TOKEN_W-1:0]     cap_q, charge_q, cur;
   logic [2*CFG_W-1:0]     prod_lo;
   logic [EHI_W+CFG_W-1:0] prod_hi;
   logic [PROD_W-1:0]      prod;
   logic                   over;
   logic [TOKEN_W:0]       refill;
   logic                   pol_ok;

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || advance;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.accepted = accepted_ff;
   assign rsp_chan.send_ns  = send_ff;

   assign charge  = CHARGE_W'(bytes_ff) + CHARGE_W'(WIRE_OVERHEAD);
   assign delayed = arrival_ff + TIME_W'(delay_ff);

   // leaky-bucket shaper
   assign later     = (nf_ns_ff > delayed) || ((nf_ns_ff == delayed) && (nf_frac_ff != '0));
   assign real_int  = later ? nf_ns_ff : delayed;
   assign real_frac = later ? nf_frac_ff : '0;
   assign back_int  = real_int - delayed;
   assign back_q    = {back_int[TIME_W-FRAC_BITS-1:0], real_frac};
   assign bound     = cap_ff * npb_ff;
   assign shp_drop  = (back_int[TIME_W-1:TIME_W-FRAC_BITS] != '0) ||
                      (back_q > TIME_W'(bound));
   assign add_ns    = charge * npb_ff;
   assign frac_sum  = {1'b0, real_frac} + {1'b0, add_ns[FRAC_BITS-1:0]};
   assign nf_next   = real_int + TIME_W'(add_ns[ADD_W-1:FRAC_BITS])
                      + TIME_W'(frac_sum[FRAC_BITS]);

   // token-bucket policer; refill saturates at the depth once level plus elapsed * rate passes it
   assign elapsed  = (arrival_ff > last_ff) ? arrival_ff - last_ff : '0;
   assign cap_q    = {cap_ff, FRAC_BITS'(0)};
   assign prod_lo  = elapsed[CFG_W-1:0] * rate_ff;
   assign prod_hi  = elapsed[TOKEN_W-1:CFG_W] * rate_ff;
   assign prod     = (PROD_W'(prod_hi) << CFG_W) + PROD_W'(prod_lo);
   assign over     = ((elapsed[TIME_W-1:TOKEN_W] != '0) && (rate_ff != '0)) ||
                     (prod > PROD_W'(cap_q));
   assign refill   = {1'b0, token_ff} + {1'b0, prod[TOKEN_W-1:0]};
   assign cur      = (over || (refill > {1'b0, cap_q})) ? cap_q : refill[TOKEN_W-1:0];
   assign charge_q = TOKEN_W'({charge, FRAC_BITS'(0)});
   assign pol_ok   = cur > charge_q;

   always_comb begin
      accepted_in = 1'b1;
      send_in     = delayed;
      last_in     = last_ff;
      token_in    = token_ff;
      nf_ns_in    = nf_ns_ff;
      nf_frac_in  = nf_frac_ff;
      case (mode_ff)
         MODE_SHAPER: begin
            if (shp_drop) begin
               accepted_in = 1'b0;
               send_in     = '0;
            end else begin
               send_in    = real_int;
               nf_ns_in   = nf_next;
               nf_frac_in = frac_sum[FRAC_BITS-1:0];
            end
         end
         MODE_POLICER: begin
            if (pol_ok) begin
               token_in = cur - charge_q;
               last_in  = arrival_ff;
            end else begin
               accepted_in = 1'b0;
               send_in     = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= '0;
         delay_ff <= '0;
         rate_ff  <= '0;
         npb_ff   <= '0;
         cap_ff   <= '0;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_SHAPING_MODE: mode_ff  <= csr_chan.data[1:0];
            CSR_ADDED_DELAY:  delay_ff <= csr_chan.data;
            CSR_BYTES_PER_NS: rate_ff  <= csr_chan.data;
            CSR_NS_PER_BYTE:  npb_ff   <= csr_chan.data;
            CSR_CAPACITY:     cap_ff   <= csr_chan.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         arrival_ff <= req_chan.arrival_ns;
         bytes_ff   <= req_chan.packet_bytes;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         last_ff      <= '0;
         token_ff     <= '0;
         nf_ns_ff     <= '0;
         nf_frac_ff   <= '0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
         if (s1_valid_ff) begin
            last_ff    <= last_in;
            token_ff   <= token_in;
            nf_ns_ff   <= nf_ns_in;
            nf_frac_ff <= nf_frac_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         accepted_ff <= accepted_in;
         send_ff     <= send_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !accepted_ff |-> send_ff == '0)
      else $error("dropped word carries a nonzero send time");

   assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> s1_valid_ff && rsp_valid_ff)
      else $error("request stalled while a stage is free");

   assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !s1_valid_ff)
      else $error("stage valid survives reset");

endmodule

FILE: bench/prsp_checker.sv
`timescale 1ns / 1ps
// Verdict scoreboard for the packet rate shaper/policer: tracks register writes, predicts each
// verdict word from the accepted packet words and compares it on rsp.
// Depends on prsp_pkg and the channel interfaces in prsp_if.sv.
module prsp_checker
   import prsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   prsp_req_if         req_mon,
   prsp_rsp_if         rsp_mon,
   prsp_csr_if         csr_mon,
   output int unsigned mismatch_count,
   output int unsigned verdicts_pending
);

   typedef struct packed {
      logic              accepted;
      logic [TIME_W-1:0] send_ns;
   } verdict_type;

   logic [1:0]           mode_sel;
   logic [CFG_W-1:0]     delay_ns;
   logic [CFG_W-1:0]     bytes_per_ns;
   logic [CFG_W-1:0]     ns_per_byte;
   logic [CFG_W-1:0]     capacity;
   logic [TIME_W-1:0]    last_accept_ns;
   logic [TIME_W-1:0]    token_level;
   logic [TIME_W-1:0]    free_ns;
   logic [FRAC_BITS-1:0] free_frac;
   verdict_type          verdict_q[$];

   function automatic verdict_type shape_or_police(input logic [TIME_W-1:0]  arrival,
                                                   input logic [BYTES_W-1:0] nbytes);
      verdict_type          v;
      logic [TIME_W-1:0]    charge, delayed, real_int, backlog, bound, serial;
      logic [TIME_W-1:0]    cap_q, elapsed, level, charge_q;
      logic [FRAC_BITS-1:0] real_frac;
      logic [FRAC_BITS:0]   frac_sum;
      logic                 later, drop;
      charge     = TIME_W'(nbytes) + TIME_W'(WIRE_OVERHEAD);
      delayed    = arrival + TIME_W'(delay_ns);
      v.accepted = 1'b1;
      v.send_ns  = delayed;
      if (mode_sel == MODE_SHAPER) begin
         later     = (free_ns > delayed) || (free_ns == delayed && free_frac != '0);
         real_int  = later ? free_ns : delayed;
         real_frac = later ? free_frac : '0;
         backlog   = real_int - delayed;
         bound     = TIME_W'(capacity) * TIME_W'(ns_per_byte);
         if ((backlog >> (TIME_W - FRAC_BITS)) != '0)
            drop = 1'b1;
         else
            drop = ((backlog << FRAC_BITS) | TIME_W'(real_frac)) > bound;
         if (drop) begin
            v.accepted = 1'b0;
            v.send_ns  = '0;
         end else begin
            serial    = charge * TIME_W'(ns_per_byte);
            frac_sum  = {1'b0, real_frac} + {1'b0, serial[FRAC_BITS-1:0]};
            free_frac = frac_sum[FRAC_BITS-1:0];
            free_ns   = real_int + (serial >> FRAC_BITS) + TIME_W'(frac_sum[FRAC_BITS]);
            v.send_ns = real_int;
         end
      end else if (mode_sel == MODE_POLICER) begin
         cap_q   = TIME_W'(capacity) << FRAC_BITS;
         elapsed = (arrival > last_accept_ns) ? arrival - last_accept_ns : '0;
         if (bytes_per_ns == '0)
            level = token_level;
         else if (elapsed > cap_q / TIME_W'(bytes_per_ns))
            level = cap_q;
         else
            level = token_level + elapsed * TIME_W'(bytes_per_ns);
         if (level > cap_q)
            level = cap_q;
         charge_q = charge << FRAC_BITS;
         if (level > charge_q) begin
            token_level    = level - charge_q;
            last_accept_ns = arrival;
         end else begin
            v.accepted = 1'b0;
            v.send_ns  = '0;
         end
      end
      return v;
   endfunction

   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         mode_sel       = MODE_DELAY;
         delay_ns       = '0;
         bytes_per_ns   = '0;
         ns_per_byte    = '0;
         capacity       = '0;
         last_accept_ns = '0;
         token_level    = '0;
         free_ns        = '0;
         free_frac      = '0;
         mismatch_count = 0;
         verdict_q.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_SHAPING_MODE: mode_sel     = csr_mon.data[1:0];
               CSR_ADDED_DELAY:  delay_ns     = csr_mon.data;
               CSR_BYTES_PER_NS: bytes_per_ns = csr_mon.data;
               CSR_NS_PER_BYTE:  ns_per_byte  = csr_mon.data;
               CSR_CAPACITY:     capacity     = csr_mon.data;
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (verdict_q.size() == 0) begin
               $error("verdict word with no packet outstanding: accepted %0b send_ns %0d",
                      rsp_mon.accepted, rsp_mon.send_ns);
               mismatch_count++;
            end else begin
               want = verdict_q.pop_front();
               if (rsp_mon.accepted !== want.accepted) begin
                  $error("accepted mismatch: expected %0b actual %0b",
                         want.accepted, rsp_mon.accepted);
                  mismatch_count++;
               end
               if (rsp_mon.send_ns !== want.send_ns) begin
                  $error("send_ns mismatch: expected %0d actual %0d",
                         want.send_ns, rsp_mon.send_ns);
                  mismatch_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            verdict_q.push_back(shape_or_police(req_mon.arrival_ns, req_mon.packet_bytes));
      end
      verdicts_pending = verdict_q.size();
   end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// Top of the packet rate shaper/policer bench: clock, reset, packet and register stimulus.
// Depends on prsp_pkg, prsp_if.sv, packet_rate_shaper_policer and prsp_checker.
module testbench;
   import prsp_pkg::*;

   localparam int unsigned ITEM_TOTAL     = 1350;
   localparam int unsigned WATCHDOG_LIMIT = 5000;
   localparam logic [1:0]  MODE_UNUSED    = 2'd3;

   logic        clock;
   logic        reset;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned items_sent;
   int unsigned quiet_cycles;
   int unsigned mismatch_count;
   int unsigned verdicts_pending;

   prsp_req_if req_bus ();
   prsp_rsp_if rsp_bus ();
   prsp_csr_if csr_bus ();

   packet_rate_shaper_policer u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   prsp_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_bus),
      .rsp_mon          (rsp_bus),
      .csr_mon          (csr_bus),
      .mismatch_count   (mismatch_count),
      .verdicts_pending (verdicts_pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_bus.ready = ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** packet_rate_shaper_policer: FAILED **");
            $finish;
         end
      end
   end

   // Called at a falling edge; drops valid after the write is taken and returns at a falling edge.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_bus.valid = 1'b0;
      @(negedge clock);
   endtask

   // Leaves valid high after the word is taken; the next word or settle_bus follows.
   task automatic send_packet(input logic [TIME_W-1:0] arrival,
                              input logic [BYTES_W-1:0] nbytes);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid        = 1'b1;
      req_bus.arrival_ns   = arrival;
      req_bus.packet_bytes = nbytes;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
      if (items_sent >= 2 * ITEM_TOTAL / 3) begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end else if (items_sent >= ITEM_TOTAL / 3) begin
         send_idle_pct = 62;
         recv_idle_pct = 23;
      end
   endtask

   task automatic settle_bus();
      req_bus.valid = 1'b0;
      while (verdicts_pending != 0) @(negedge clock);
   endtask

   function automatic logic [CFG_W-1:0] pick_cfg(input int unsigned lo, input int unsigned hi);
      int unsigned roll;
      roll = $urandom_range(15);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      if (roll == 2) return $urandom;
      return $urandom_range(hi, lo);
   endfunction

   initial begin
      logic [TIME_W-1:0] time_cursor;
      logic [TIME_W-1:0] arrival;
      logic [1:0]        mode_pick;
      int unsigned       step_max;
      int unsigned       burst;
      int unsigned       roll;
      req_bus.valid        = 1'b0;
      req_bus.arrival_ns   = '0;
      req_bus.packet_bytes = '0;
      csr_bus.valid        = 1'b0;
      csr_bus.index        = '0;
      csr_bus.data         = '0;
      send_idle_pct        = 23;
      recv_idle_pct        = 62;
      items_sent           = 0;
      quiet_cycles         = 0;
      reset                = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // delay only with reset registers
      send_packet(64'd0, 16'd0);
      send_packet('1, 16'hFFFF);
      settle_bus();
      // unused mode with max delay: send time wraps
      write_reg(CSR_ADDED_DELAY, '1);
      write_reg(CSR_SHAPING_MODE, {30'h3FFF_FFFF, MODE_UNUSED});
      send_packet('1, 16'd0);
      send_packet(64'h8000_0000_0000_0000, 16'h5A5A);
      settle_bus();
      write_reg(CSR_IDX_W'($urandom_range((1 << CSR_IDX_W) - 1, int'(CSR_CAPACITY) + 1)),
                $urandom);
      // shaper: backlog builds until a drop, then an idle gap clears it
      write_reg(CSR_ADDED_DELAY, 32'd10);
      write_reg(CSR_NS_PER_BYTE, 32'h0001_0000);
      write_reg(CSR_CAPACITY, 32'd100);
      write_reg(CSR_SHAPING_MODE, 32'(MODE_SHAPER));
      send_packet(64'd1000, 16'd0);
      send_packet(64'd1000, 16'd50);
      send_packet(64'd1000, 16'hFFFF);
      send_packet(64'd1000, 16'd0);
      send_packet(64'd100000, 16'd10);
      settle_bus();
      // zero serialization time: any backlog drops
      write_reg(CSR_NS_PER_BYTE, 32'd0);
      send_packet(64'd100000, 16'd0);
      send_packet(64'd200000, 16'd0);
      send_packet(64'd200000, 16'd5);
      settle_bus();
      // policer: full bucket, arrivals before last accept, overspend, then a charge the remaining level covers
      write_reg(CSR_BYTES_PER_NS, 32'h0001_0000);
      write_reg(CSR_CAPACITY, 32'd2000);
      write_reg(CSR_SHAPING_MODE, 32'(MODE_POLICER));
      send_packet(64'd5000, 16'd100);
      send_packet(64'd4000, 16'd100);
      send_packet(64'd4000, 16'd2000);
      send_packet(64'd4010, 16'd1700);
      settle_bus();
      // zero refill rate
      write_reg(CSR_BYTES_PER_NS, 32'd0);
      send_packet(64'd100000, 16'd0);
      send_packet(64'd100000, 16'd0);
      settle_bus();
      // register extremes, then mode changes keep bucket state
      write_reg(CSR_BYTES_PER_NS, '1);
      write_reg(CSR_NS_PER_BYTE, '1);
      write_reg(CSR_CAPACITY, '1);
      send_packet(64'd200000, 16'hFFFF);
      settle_bus();
      write_reg(CSR_SHAPING_MODE, 32'(MODE_SHAPER));
      send_packet(64'hFFFF_FFFF_FFFF_FFF0, 16'hFFFF);
      send_packet(64'hFFFF_FFFF_FFFF_FFF8, 16'd1);
      settle_bus();
      write_reg(CSR_SHAPING_MODE, 32'(MODE_DELAY));
      send_packet(64'd300000, 16'd64);

      time_cursor = 64'd1_000_000;
      while (items_sent < ITEM_TOTAL) begin
         settle_bus();
         case ($urandom_range(9))
            0:          mode_pick = MODE_DELAY;
            1:          mode_pick = MODE_UNUSED;
            2, 3, 4, 5: mode_pick = MODE_SHAPER;
            default:    mode_pick = MODE_POLICER;
         endcase
         write_reg(CSR_ADDED_DELAY, pick_cfg(0, 5000));
         write_reg(CSR_BYTES_PER_NS, pick_cfg(1 << 12, 1 << 18));
         write_reg(CSR_NS_PER_BYTE, pick_cfg(1 << 12, 1 << 18));
         write_reg(CSR_CAPACITY, pick_cfg(64, 20000));
         write_reg(CSR_SHAPING_MODE,
                   {($urandom_range(7) == 0) ? 30'($urandom) : 30'd0, mode_pick});
         if ($urandom_range(15) == 0)
            write_reg(CSR_IDX_W'($urandom_range((1 << CSR_IDX_W) - 1,
                                                int'(CSR_CAPACITY) + 1)), $urandom);
         if ($urandom_range(7) == 0)
            time_cursor = {$urandom, $urandom};
         case ($urandom_range(3))
            0:       step_max = 20;
            1:       step_max = 300;
            2:       step_max = 2000;
            default: step_max = 20000;
         endcase
         burst = $urandom_range(110, 40);
         repeat (burst) begin
            roll = $urandom_range(99);
            if (roll < 5) begin
               arrival = {$urandom, $urandom};
            end else begin
               time_cursor += TIME_W'($urandom_range(step_max));
               arrival = time_cursor;
            end
            roll = $urandom_range(99);
            if (roll < 80)
               send_packet(arrival, BYTES_W'($urandom_range(1500)));
            else if (roll < 90)
               send_packet(arrival, BYTES_W'($urandom));
            else
               send_packet(arrival, BYTES_W'($urandom_range(63)));
         end
      end

      settle_bus();
      repeat (8) @(negedge clock);
      if (mismatch_count == 0)
         $display("** packet_rate_shaper_policer: PASSED **");
      else
         $display("** packet_rate_shaper_policer: FAILED **");
      $finish;
   end

endmodule
